### hw/rtl/krt_pkg.sv
package krt_pkg;

  // Operation requested by one command beat.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LIST   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DELETE = 2'd3
  } opcode_e;

  // Status reported with each result beat.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned NameW  = 64;
  localparam int unsigned MarkW  = 16;
  localparam int unsigned CountW = 7;

  typedef struct packed {
    opcode_e                  opcode;
    logic signed [KeyW-1:0]   key;
    logic        [NameW-1:0]  name_tag;
    logic        [MarkW-1:0]  mark;
  } krt_cmd_t;

  typedef struct packed {
    status_e                  status;
    logic signed [KeyW-1:0]   out_key;
    logic        [NameW-1:0]  out_name;
    logic        [MarkW-1:0]  out_mark;
    logic        [CountW-1:0] record_count;
    logic                     last;
  } krt_res_t;

  // One stored record, as held in a single RAM word.
  typedef struct packed {
    logic signed [KeyW-1:0]   key;
    logic        [NameW-1:0]  name;
    logic        [MarkW-1:0]  mark;
  } krt_rec_t;

  localparam int unsigned RecW = $bits(krt_rec_t);

  // Result of the shared compare unit for the record under inspection.
  typedef struct packed {
    logic hit;     // stored key equals the key of the command
    logic at_end;  // record is the last one held
  } krt_match_t;

endpackage

### hw/rtl/krt_ram.sv
module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/krt_match.sv
module krt_match #(
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic signed [krt_pkg::KeyW-1:0] rec_key_i,
  input  logic signed [krt_pkg::KeyW-1:0] cmd_key_i,
  input  logic        [AW-1:0]            idx_i,
  input  logic        [CW-1:0]            count_i,
  output krt_pkg::krt_match_t             match_o
);

  logic [CW-1:0] last_idx;

  // The table is never empty while a record is being inspected.
  assign last_idx       = count_i - CW'(1);
  assign match_o.hit    = (rec_key_i == cmd_key_i);
  assign match_o.at_end = (CW'(idx_i) == last_idx);

endmodule

### hw/rtl/keyed_record_table_core.sv
// Keyed record table. The table keeps up to TABLE_DEPTH records (signed key,
// name of NAME_BYTES bytes, mark in hundredths) in insertion order in one
// single-port-read RAM, and works through one command at a time. A command
// beat is taken when start is high and busy is low; a command that walks the
// records raises busy, which stays high until the final result beat has been
// issued. Each result beat appears on res_o for exactly one cycle with
// res_valid_o high and must be taken then, as the receiver has no means to
// stall the block. Add returns one beat. List returns one beat per record,
// one per cycle. Search walks the records through the single RAM read port
// and the single key comparator, one record per cycle. Delete walks to the
// first match and then moves every later record down one place, one record
// per cycle through the same read port. Every command ends with a beat that
// has last set. The RAM is not cleared after reset; only entries below the
// record count are ever read.
module keyed_record_table_core #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned NAME_BYTES  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  krt_pkg::krt_cmd_t cmd_i,
  output logic              res_valid_o,
  output krt_pkg::krt_res_t res_o
);

  // Address width for the RAM and count width that can hold TABLE_DEPTH.
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // Only the leading NAME_BYTES bytes of a name are kept.
  localparam logic [krt_pkg::NameW-1:0] NameMask =
    {krt_pkg::NameW{1'b1}} << (8 * (8 - NAME_BYTES));

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SHIFT
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic                vld_q, vld_d;
  logic [AW-1:0]       vld_idx_q, vld_idx_d;
  krt_pkg::opcode_e    op_q, op_d;
  logic signed [krt_pkg::KeyW-1:0] key_q, key_d;
  krt_pkg::krt_rec_t   hold_q, hold_d;
  logic                res_valid_q, res_valid_d;
  krt_pkg::krt_res_t   res_q, res_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  krt_pkg::krt_rec_t   ram_wdata;
  logic                ram_re;
  krt_pkg::krt_rec_t   ram_rdata;
  krt_pkg::krt_match_t match;
  krt_pkg::krt_rec_t   new_rec;
  logic [31:0]         cnt_ext;

  krt_ram #(
    .WIDTH (krt_pkg::RecW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // The one comparator that every scan step goes through.
  krt_match #(
    .AW (AW),
    .CW (CW)
  ) u_match (
    .rec_key_i (ram_rdata.key),
    .cmd_key_i (key_q),
    .idx_i     (vld_idx_q),
    .count_i   (cnt_q),
    .match_o   (match)
  );

  function automatic krt_pkg::krt_res_t make_res(krt_pkg::status_e  status,
                                                 krt_pkg::krt_rec_t rec,
                                                 logic              last);
    krt_pkg::krt_res_t r;
    r.status       = status;
    r.out_key      = rec.key;
    r.out_name     = rec.name;
    r.out_mark     = rec.mark;
    r.record_count = '0;
    r.last         = last;
    return r;
  endfunction

  assign new_rec.key  = cmd_i.key;
  assign new_rec.name = cmd_i.name_tag & NameMask;
  assign new_rec.mark = cmd_i.mark;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    vld_d       = 1'b0;
    vld_idx_d   = vld_idx_q;
    op_d        = op_q;
    key_d       = key_q;
    hold_d      = hold_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = vld_idx_q - AW'(1);
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;

    unique case (state_q)
      IDLE: begin
        if (start) begin
          op_d  = cmd_i.opcode;
          key_d = cmd_i.key;
          unique case (cmd_i.opcode)
            krt_pkg::OP_ADD: begin
              res_valid_d = 1'b1;
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                res_d = make_res(krt_pkg::ST_FULL, '0, 1'b1);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[AW-1:0];
                ram_wdata = new_rec;
                cnt_d     = cnt_q + CW'(1);
                res_d     = make_res(krt_pkg::ST_OK, new_rec, 1'b1);
              end
            end
            krt_pkg::OP_LIST, krt_pkg::OP_SEARCH, krt_pkg::OP_DELETE: begin
              if (cnt_q == '0) begin
                res_valid_d = 1'b1;
                res_d = make_res((cmd_i.opcode == krt_pkg::OP_LIST) ?
                                 krt_pkg::ST_EMPTY : krt_pkg::ST_NOT_FOUND,
                                 '0, 1'b1);
              end else begin
                state_d  = SCAN;
                rd_idx_d = '0;
              end
            end
          endcase
        end
      end

      SCAN: begin
        if (rd_idx_q < cnt_q) begin
          ram_re    = 1'b1;
          vld_d     = 1'b1;
          vld_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
        end
        if (vld_q) begin
          unique case (op_q)
            krt_pkg::OP_LIST: begin
              res_valid_d = 1'b1;
              res_d       = make_res(krt_pkg::ST_OK, ram_rdata, match.at_end);
              if (match.at_end) begin
                state_d = IDLE;
              end
            end
            krt_pkg::OP_SEARCH, krt_pkg::OP_DELETE: begin
              if (match.hit) begin
                hold_d = ram_rdata;
                if ((op_q == krt_pkg::OP_SEARCH) || match.at_end) begin
                  // A match on the last record needs no compaction.
                  if (op_q == krt_pkg::OP_DELETE) begin
                    cnt_d = cnt_q - CW'(1);
                  end
                  res_valid_d = 1'b1;
                  res_d       = make_res(krt_pkg::ST_OK, ram_rdata, 1'b1);
                  state_d     = IDLE;
                end else begin
                  // Restart reading just above the hole.
                  state_d  = SHIFT;
                  vld_d    = 1'b0;
                  rd_idx_d = CW'(vld_idx_q) + CW'(1);
                end
              end else if (match.at_end) begin
                res_valid_d = 1'b1;
                res_d       = make_res(krt_pkg::ST_NOT_FOUND, '0, 1'b1);
                state_d     = IDLE;
              end
            end
            krt_pkg::OP_ADD: begin
            end
          endcase
        end
      end

      SHIFT: begin
        if (rd_idx_q < cnt_q) begin
          ram_re    = 1'b1;
          vld_d     = 1'b1;
          vld_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
        end
        if (vld_q) begin
          // Each record read moves down one place.
          ram_we = 1'b1;
          if (match.at_end) begin
            cnt_d       = cnt_q - CW'(1);
            res_valid_d = 1'b1;
            res_d       = make_res(krt_pkg::ST_OK, hold_q, 1'b1);
            state_d     = IDLE;
          end
        end
      end

      default: begin
        state_d = IDLE;
      end
    endcase

    // The count reported is the one after this command.
    cnt_ext            = 32'(cnt_d);
    res_d.record_count = cnt_ext[krt_pkg::CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      vld_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      vld_q       <= vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    vld_idx_q <= vld_idx_d;
    op_q      <= op_d;
    key_q     <= key_d;
    hold_q    <= hold_d;
    res_q     <= res_d;
  end

  assign busy        = (state_q != IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The final beat of a command leaves the block ready for the next one.
  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("final result beat issued while still busy");

  // Intermediate list beats only occur while the command is still running.
  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final result beat after the command ended");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("record count exceeds table depth");

  // Compaction writes stay inside the records held.
  a_shift_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SHIFT) && ram_we |-> (CW'(ram_waddr) < cnt_q))
    else $error("compaction write beyond the record count");

  // A scan command taken on a non-empty table raises busy and gives no immediate result beat.
  a_accept_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.opcode != krt_pkg::OP_ADD) && (cnt_q != '0)
      |=> busy && !res_valid_o)
    else $error("scan command did not enter its walk");

endmodule

### test/tb_top.sv
module tb_top;

  // Geometry of the table under test; the mirror below uses the same values.
  localparam int unsigned TableDepth = 64;
  localparam int unsigned NameBytes  = 8;

  // Generous bound on the whole run, in clock cycles. The run is 180 commands
  // with sender gaps between them, so this leaves a wide margin.
  localparam int CycleLimit = 400000;

  // Settling time after the final beat, before the verdict is given.
  localparam int TailCycles = 8;

  // Only the leading NameBytes bytes of a name are kept on add.
  localparam logic [krt_pkg::NameW-1:0] NameKeepMask =
    {krt_pkg::NameW{1'b1}} << (8 * (8 - NameBytes));

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start  = 1'b0;
  logic              busy;
  krt_pkg::krt_cmd_t cmd_i  = '0;
  logic              res_valid_o;
  krt_pkg::krt_res_t res_o;

  // Mirror of the table contents and fill level, updated as each command beat
  // is taken.
  krt_pkg::krt_rec_t held_recs [TableDepth];
  int unsigned       held_count = 0;

  krt_pkg::krt_cmd_t pending_cmds[$];    // commands still to be offered to the block
  krt_pkg::krt_res_t expected_beats[$];  // result beats worked out but not yet seen

  int idle_pct    = 0;          // chance, in percent, that the sender idles a cycle
  int error_count = 0;
  int cycle_count = 0;
  bit beat_taken  = 1'b0;       // a command beat was taken at the last rising edge

  // Keys drawn often, so that searches and deletes find their targets and
  // duplicates arise. The extremes of the signed range are included.
  logic signed [krt_pkg::KeyW-1:0] key_pool [0:9] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff, 32'sh0000_0001,
    32'sh0000_0007, 32'sh0000_0064, 32'shffff_ff9c, 32'sh1234_5678, 32'sh5a5a_a5a5
  };

  keyed_record_table_core #(
    .TABLE_DEPTH(TableDepth),
    .NAME_BYTES (NameBytes)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic flag_error(string msg);
    $display("cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic compare_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s is %0h, %0h was due", field, got, want));
    end
  endtask

  // Applies one taken command to the mirrored table and queues the result
  // beats that it must produce. Every command ends in exactly one beat with
  // last set; a listing of a populated table gives one beat per record.
  task automatic apply_command(krt_pkg::krt_cmd_t c);
    krt_pkg::krt_res_t beat;
    int unsigned       idx;
    beat      = '0;
    beat.last = 1'b1;
    case (c.opcode)
      krt_pkg::OP_ADD: begin
        if (held_count >= TableDepth) begin
          beat.status = krt_pkg::ST_FULL;
        end else begin
          held_recs[held_count].key  = c.key;
          held_recs[held_count].name = c.name_tag & NameKeepMask;
          held_recs[held_count].mark = c.mark;
          beat.status   = krt_pkg::ST_OK;
          beat.out_key  = held_recs[held_count].key;
          beat.out_name = held_recs[held_count].name;
          beat.out_mark = held_recs[held_count].mark;
          held_count++;
        end
      end
      krt_pkg::OP_LIST: begin
        if (held_count == 0) begin
          beat.status = krt_pkg::ST_EMPTY;
        end else begin
          // All but the final record beat are queued here; the final one is
          // queued below together with every other kind of closing beat.
          for (idx = 0; idx < held_count; idx++) begin
            beat.status       = krt_pkg::ST_OK;
            beat.out_key      = held_recs[idx].key;
            beat.out_name     = held_recs[idx].name;
            beat.out_mark     = held_recs[idx].mark;
            beat.record_count = krt_pkg::CountW'(held_count);
            beat.last         = (idx + 1 == held_count);
            if (!beat.last) begin
              expected_beats.push_back(beat);
            end
          end
        end
      end
      default: begin
        idx = 0;
        while (idx < held_count && held_recs[idx].key != c.key) begin
          idx++;
        end
        if (idx >= held_count) begin
          beat.status = krt_pkg::ST_NOT_FOUND;
        end else begin
          beat.status   = krt_pkg::ST_OK;
          beat.out_key  = held_recs[idx].key;
          beat.out_name = held_recs[idx].name;
          beat.out_mark = held_recs[idx].mark;
          if (c.opcode == krt_pkg::OP_DELETE) begin
            // Later records close the gap, keeping insertion order.
            for (; idx + 1 < held_count; idx++) begin
              held_recs[idx] = held_recs[idx + 1];
            end
            held_count--;
          end
        end
      end
    endcase
    beat.record_count = krt_pkg::CountW'(held_count);
    expected_beats.push_back(beat);
  endtask

  task automatic queue_cmd(krt_pkg::opcode_e op, logic signed [krt_pkg::KeyW-1:0] key,
                           logic [krt_pkg::NameW-1:0] name,
                           logic [krt_pkg::MarkW-1:0] mark);
    krt_pkg::krt_cmd_t c;
    c.opcode   = op;
    c.key      = key;
    c.name_tag = name;
    c.mark     = mark;
    pending_cmds.push_back(c);
  endtask

  // Queues random commands with the given mix of operations (the remainder is
  // deletes). Half the keys come from the pool, the rest are fully random.
  task automatic queue_random(int count, int add_pct, int list_pct, int search_pct);
    int                              pick;
    krt_pkg::opcode_e                op;
    logic signed [krt_pkg::KeyW-1:0] key;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < add_pct) begin
        op = krt_pkg::OP_ADD;
      end else if (pick < add_pct + list_pct) begin
        op = krt_pkg::OP_LIST;
      end else if (pick < add_pct + list_pct + search_pct) begin
        op = krt_pkg::OP_SEARCH;
      end else begin
        op = krt_pkg::OP_DELETE;
      end
      if ($urandom_range(0, 1) == 1) begin
        key = key_pool[$urandom_range(0, 9)];
      end else begin
        key = $urandom;
      end
      queue_cmd(op, key, {$urandom, $urandom},
                krt_pkg::MarkW'($urandom_range(0, 65535)));
    end
  endtask

  // Waits until every queued command has been taken and every beat seen.
  task automatic drain;
    while (pending_cmds.size() != 0 || expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sender. It works at the falling edge, so that the block sees stable
  // inputs at the rising edge. A command that has been offered is held until
  // it is taken; otherwise the sender either offers the next command or idles,
  // as the current idle chance decides. Start gets one assignment per step.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      start <= 1'b1;
    end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      start <= 1'b1;
      cmd_i <= pending_cmds[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Receiver and checker. At each rising edge the result beat on the ports,
  // if any, is checked against the oldest expectation first; only then is a
  // command taken at this same edge applied to the mirror, so its own beats
  // (which can only come later) never mix with the check.
  always @(posedge clk_i) begin
    krt_pkg::krt_res_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      beat_taken = 1'b0;
      if (rst_ni) begin
        if (res_valid_o) begin
          if (expected_beats.size() == 0) begin
            flag_error("result beat with none outstanding");
          end else begin
            want = expected_beats.pop_front();
            compare_field("status", 64'(res_o.status), 64'(want.status));
            compare_field("out_key", 64'(res_o.out_key), 64'(want.out_key));
            compare_field("out_name", res_o.out_name, want.out_name);
            compare_field("out_mark", 64'(res_o.out_mark), 64'(want.out_mark));
            compare_field("record_count", 64'(res_o.record_count),
                          64'(want.record_count));
            compare_field("last", 64'(res_o.last), 64'(want.last));
          end
        end
        if (start && !busy) begin
          beat_taken = 1'b1;
          apply_command(cmd_i);
          void'(pending_cmds.pop_front());
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    // Directed part: empty table cases, the key and mark extremes, duplicate
    // keys, deletion at the front, middle and end, and emptying again.
    idle_pct = 0;
    queue_cmd(krt_pkg::OP_LIST, 32'sd0, '0, '0);
    queue_cmd(krt_pkg::OP_SEARCH, 32'sd5, '0, '0);
    queue_cmd(krt_pkg::OP_DELETE, 32'sd5, '0, '0);
    queue_cmd(krt_pkg::OP_ADD, 32'sh8000_0000, {krt_pkg::NameW{1'b1}},
              {krt_pkg::MarkW{1'b1}});
    queue_cmd(krt_pkg::OP_ADD, 32'sh7fff_ffff, '0, '0);
    queue_cmd(krt_pkg::OP_ADD, 32'sd0, 64'h0123_4567_89ab_cdef, 16'd1);
    queue_cmd(krt_pkg::OP_ADD, -32'sd1, 64'h8000_0000_0000_0001, 16'h8000);
    queue_cmd(krt_pkg::OP_ADD, 32'sd7, 64'h4142_4344_4546_4748, 16'd100);
    queue_cmd(krt_pkg::OP_ADD, 32'sd7, 64'h6162_6364_0000_0000, 16'd200);
    queue_cmd(krt_pkg::OP_LIST, 32'sd0, '0, '0);
    queue_cmd(krt_pkg::OP_SEARCH, 32'sd7, '0, '0);
    queue_cmd(krt_pkg::OP_SEARCH, 32'sh8000_0000, '0, '0);
    queue_cmd(krt_pkg::OP_SEARCH, 32'sd12345, '0, '0);
    queue_cmd(krt_pkg::OP_DELETE, 32'sd7, '0, '0);
    queue_cmd(krt_pkg::OP_SEARCH, 32'sd7, '0, '0);
    queue_cmd(krt_pkg::OP_DELETE, 32'sh8000_0000, '0, '0);
    queue_cmd(krt_pkg::OP_DELETE, 32'sd7, '0, '0);
    queue_cmd(krt_pkg::OP_DELETE, 32'sd999, '0, '0);
    queue_cmd(krt_pkg::OP_LIST, 32'sd0, '0, '0);
    queue_cmd(krt_pkg::OP_DELETE, 32'sh7fff_ffff, '0, '0);
    queue_cmd(krt_pkg::OP_DELETE, 32'sd0, '0, '0);
    queue_cmd(krt_pkg::OP_DELETE, -32'sd1, '0, '0);
    queue_cmd(krt_pkg::OP_LIST, 32'sd0, '0, '0);
    queue_cmd(krt_pkg::OP_ADD, 32'sh5a5a_a5a5, 64'hfedc_ba98_7654_3210, 16'd4321);

    // Fill the table to the brim and a few beyond, so that full is reported,
    // then list, search and delete on a full table; all without idling.
    queue_random(66, 100, 0, 0);
    queue_random(10, 10, 30, 30);
    drain();

    // A busy mix with a mostly idle sender, then with an occasional gap.
    idle_pct = 84;
    queue_random(40, 25, 10, 30);
    drain();
    idle_pct = 23;
    queue_random(40, 30, 10, 30);
    drain();

    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
